// ===== design/rch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region color homogeneity: shared types, constants and functions
// Holds field widths, register indexes, the YCbCr conversion and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rch_pkg;

    // Color and field widths.
    localparam int COLOR_W  = 8;
    localparam int CNT_W    = 17;
    localparam int SUM_W    = 32;
    localparam int DEV_W    = 16;
    localparam int SCORE_W  = 17;
    localparam int FRAC_W   = 16;
    localparam int NUM_W    = SUM_W + FRAC_W;
    localparam int DEN_W    = 32;

    // Stream widths.
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_REF_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_BLUE  = 2'd2;

    // Limits and scaling.
    localparam int MAX_PIXELS = 65536;
    localparam int FULL_SCALE = 25500;
    localparam int SCORE_MAX  = 65536;
    localparam int W_LUMA     = 70;
    localparam int W_CHROMA   = 15;

    // Divider: one quotient bit per cycle over the whole numerator.
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [COLOR_W-1:0] y;
        logic [COLOR_W-1:0] cb;
        logic [COLOR_W-1:0] cr;
    } ycc_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // input side may take a beat
        logic load;     // latch sum and count into the divider, clear them
        logic step;     // one division step
        logic publish;  // write the result into the output register
    } rch_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic last_in_flight;  // a last-marked beat is still in the pipe
        logic acc_last;        // the last-marked beat is being accumulated
        logic out_valid;       // the output register holds a result
    } rch_status_t;

    // Integer BT.601 conversion with a floor shift.
    function automatic ycc_t rgb_to_ycc(input logic [COLOR_W-1:0] r,
                                        input logic [COLOR_W-1:0] g,
                                        input logic [COLOR_W-1:0] b);
        logic signed [17:0] ri;
        logic signed [17:0] gi;
        logic signed [17:0] bi;
        logic signed [17:0] ys;
        logic signed [17:0] cbs;
        logic signed [17:0] crs;
        logic signed [17:0] yf;
        logic signed [17:0] cbf;
        logic signed [17:0] crf;
        ycc_t res;
        ri  = $signed({10'b0, r});
        gi  = $signed({10'b0, g});
        bi  = $signed({10'b0, b});
        ys  = 18'sd66 * ri + 18'sd129 * gi + 18'sd25 * bi + 18'sd128;
        cbs = -18'sd38 * ri - 18'sd74 * gi + 18'sd112 * bi + 18'sd128;
        crs = 18'sd112 * ri - 18'sd94 * gi - 18'sd18 * bi + 18'sd128;
        yf  = (ys >>> 8) + 18'sd16;
        cbf = (cbs >>> 8) + 18'sd128;
        crf = (crs >>> 8) + 18'sd128;
        res.y  = yf[COLOR_W-1:0];
        res.cb = cbf[COLOR_W-1:0];
        res.cr = crf[COLOR_W-1:0];
        return res;
    endfunction

endpackage

// ===== design/rch_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region color homogeneity: controller
// Sequences streaming, divider load, the division steps and the hand-off of
// the result into the output register.
// ----------------------------------------------------------------------------
module rch_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rch_pkg::rch_status_t status,
    output rch_pkg::rch_cmd_t    cmd
);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [rch_pkg::STEP_W-1:0]   step_reg;
    logic [rch_pkg::STEP_W-1:0]   step_next;

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd.accept  = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.publish = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                cmd.accept = ~status.last_in_flight;
                if (status.acc_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (step_reg == rch_pkg::STEP_W'(rch_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_HOLD:
            begin
                // Wait until the previous result has been taken.
                if (!status.out_valid)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== design/rch_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region color homogeneity: datapath
// Reference registers, the conversion and deviation pipeline, the
// accumulators, a bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module rch_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic [rch_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    input  logic                              cfg_we,
    input  logic [rch_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rch_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  rch_pkg::rch_cmd_t                 cmd,
    output rch_pkg::rch_status_t              status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rch_pkg::M_DATA_W-1:0]      m_tdata
);

    logic [rch_pkg::COLOR_W-1:0] ref_red_reg;
    logic [rch_pkg::COLOR_W-1:0] ref_green_reg;
    logic [rch_pkg::COLOR_W-1:0] ref_blue_reg;
    rch_pkg::ycc_t               ref_ycc_reg;

    logic                        v1_reg;
    logic                        l1_reg;
    logic                        p1_reg;
    rch_pkg::ycc_t               ycc1_reg;

    logic                        v2_reg;
    logic                        l2_reg;
    logic                        p2_reg;
    logic [rch_pkg::DEV_W-1:0]   dev2_reg;

    logic [rch_pkg::SUM_W-1:0]   sum_reg;
    logic [rch_pkg::SUM_W-1:0]   sum_next;
    logic [rch_pkg::CNT_W-1:0]   count_reg;
    logic [rch_pkg::CNT_W-1:0]   count_next;

    logic [rch_pkg::DEN_W-1:0]   den_reg;
    logic [rch_pkg::DEN_W-1:0]   rem_reg;
    logic [rch_pkg::NUM_W-1:0]   quo_reg;
    logic                        zero_reg;
    logic [rch_pkg::CNT_W-1:0]   seen_reg;

    logic                        out_valid_reg;
    logic [rch_pkg::SCORE_W-1:0] score_reg;
    logic [rch_pkg::CNT_W-1:0]   pixels_reg;

    logic                        accept;
    logic [rch_pkg::COLOR_W-1:0] d_y;
    logic [rch_pkg::COLOR_W-1:0] d_cb;
    logic [rch_pkg::COLOR_W-1:0] d_cr;
    logic [rch_pkg::DEV_W-1:0]   dev;
    logic [rch_pkg::SUM_W:0]     sum_wide;
    logic [rch_pkg::DEN_W:0]     trial;
    logic [rch_pkg::DEN_W:0]     diff;
    logic                        ge;
    logic [rch_pkg::SCORE_W-1:0] score_val;

    assign accept = s_tvalid & cmd.accept;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_red_reg   <= '0;
            ref_green_reg <= '0;
            ref_blue_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rch_pkg::REG_REF_RED:   ref_red_reg   <= cfg_data;
                rch_pkg::REG_REF_GREEN: ref_green_reg <= cfg_data;
                rch_pkg::REG_REF_BLUE:  ref_blue_reg  <= cfg_data;
                default:                ref_red_reg   <= ref_red_reg;
            endcase
        end
    end

    // Reference color in YCbCr, refreshed every cycle.
    always_ff @(posedge clk)
    begin
        ref_ycc_reg <= rch_pkg::rgb_to_ycc(ref_red_reg, ref_green_reg, ref_blue_reg);
    end

    // Stage one: convert the incoming pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            l1_reg   <= s_tlast;
            p1_reg   <= s_tuser;
            ycc1_reg <= rch_pkg::rgb_to_ycc(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
        end
    end

    // Stage two: weighted absolute deviation from the reference.
    always_comb
    begin
        d_y  = (ycc1_reg.y >= ref_ycc_reg.y) ? ycc1_reg.y - ref_ycc_reg.y
                                             : ref_ycc_reg.y - ycc1_reg.y;
        d_cb = (ycc1_reg.cb >= ref_ycc_reg.cb) ? ycc1_reg.cb - ref_ycc_reg.cb
                                               : ref_ycc_reg.cb - ycc1_reg.cb;
        d_cr = (ycc1_reg.cr >= ref_ycc_reg.cr) ? ycc1_reg.cr - ref_ycc_reg.cr
                                               : ref_ycc_reg.cr - ycc1_reg.cr;
        dev  = rch_pkg::DEV_W'(rch_pkg::W_LUMA) * rch_pkg::DEV_W'(d_y)
             + rch_pkg::DEV_W'(rch_pkg::W_CHROMA)
               * (rch_pkg::DEV_W'(d_cb) + rch_pkg::DEV_W'(d_cr));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            l2_reg   <= l1_reg;
            p2_reg   <= p1_reg;
            dev2_reg <= dev;
        end
    end

    // Stage three: saturating accumulation, pixel count capped at the limit.
    always_comb
    begin
        sum_wide   = {1'b0, sum_reg} + (rch_pkg::SUM_W + 1)'(dev2_reg);
        sum_next   = sum_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            sum_next   = '0;
            count_next = '0;
        end
        else if (v2_reg && p2_reg && (count_reg < rch_pkg::CNT_W'(rch_pkg::MAX_PIXELS)))
        begin
            sum_next   = sum_wide[rch_pkg::SUM_W] ? '1 : sum_wide[rch_pkg::SUM_W-1:0];
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // Restoring divider, one quotient bit per step.
    always_comb
    begin
        trial = {rem_reg, quo_reg[rch_pkg::NUM_W-1]};
        ge    = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            den_reg  <= rch_pkg::DEN_W'(count_reg) * rch_pkg::DEN_W'(rch_pkg::FULL_SCALE);
            rem_reg  <= '0;
            quo_reg  <= {sum_reg, {rch_pkg::FRAC_W{1'b0}}};
            zero_reg <= (count_reg == '0);
            seen_reg <= count_reg;
        end
        else if (cmd.step)
        begin
            rem_reg <= ge ? diff[rch_pkg::DEN_W-1:0] : trial[rch_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[rch_pkg::NUM_W-2:0], ge};
        end
    end

    // Score clamp; an empty region scores zero.
    always_comb
    begin
        if (zero_reg)
        begin
            score_val = '0;
        end
        else if (quo_reg > rch_pkg::NUM_W'(rch_pkg::SCORE_MAX))
        begin
            score_val = rch_pkg::SCORE_W'(rch_pkg::SCORE_MAX);
        end
        else
        begin
            score_val = quo_reg[rch_pkg::SCORE_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            score_reg  <= score_val;
            pixels_reg <= seen_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rch_pkg::M_DATA_W - rch_pkg::SCORE_W - rch_pkg::CNT_W){1'b0}},
                       pixels_reg, score_reg};

    assign status.last_in_flight = (v1_reg & l1_reg) | (v2_reg & l2_reg);
    assign status.acc_last       = v2_reg & l2_reg;
    assign status.out_valid      = out_valid_reg;

endmodule

// ===== design/region_color_homogeneity.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region color homogeneity
// Mean weighted YCbCr deviation of a pixel region from a reference color.
// ----------------------------------------------------------------------------
// Input stream: one beat per item. s_tdata holds red, green and blue; s_tuser
// marks that the beat carries a pixel; s_tlast marks the last beat of a
// region. Pixel beats are taken one per cycle, except while a region's score is computed.
// Output stream: one beat per region, holding the score (Q1.16) and the
// number of pixels counted.
// The reference color is written through cfg_we/cfg_index/cfg_data while the
// block is idle; this binds the user, as the block itself does not enforce it.
// After a last beat the input stalls while the score is computed: two
// pipeline stages, a load step, the bit-serial divider and a publish step
// that waits until an earlier result has been taken; the result is offered
// and the next region may start in that same cycle.
// The output sits in a register; while the receiver stalls the block keeps
// taking the next region, and it waits only if that region ends before the
// earlier result has been taken.
// Reset clears the reference color, the sums and all handshake state.
// ----------------------------------------------------------------------------
module region_color_homogeneity
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rch_pkg::S_DATA_W-1:0]   s_tdata,   // red, green, blue
    input  logic                           s_tuser,   // pixel_present
    input  logic                           s_tlast,   // end_of_region
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rch_pkg::M_DATA_W-1:0]   m_tdata,   // score, pixels_seen
    input  logic                           cfg_we,
    input  logic [rch_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rch_pkg::CFG_DATA_W-1:0] cfg_data
);

    rch_pkg::rch_cmd_t    cmd;
    rch_pkg::rch_status_t status;

    rch_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    rch_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    assign s_tready = cmd.accept;

endmodule

// ===== design/rch_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region color homogeneity: port checker
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module rch_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rch_pkg::M_DATA_W-1:0]   m_tdata
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // The score never exceeds one in Q1.16.
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:0] <= 17'd65536))
        else $error("score out of range");

    // A region without pixels scores zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:17] == 17'd0) |-> (m_tdata[16:0] == 17'd0))
        else $error("empty region with nonzero score");

    // After the last beat of a region the input waits for the score.
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken while the region result is pending");

endmodule

bind region_color_homogeneity rch_checker u_rch_checker (.*);

// ===== tb/region_color_homogeneity_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region color homogeneity testbench
// Streams RGB pixel regions into the block and compares every score beat
// against a scoreboard fed by a behavioral model of the BT.601 deviation
// math. Directed tests cover empty regions, color extremes, regions that
// close on a pixelless beat and the spare register index.
// A long output hold-off fills the block. A random phase with changing
// reference colors and random stalls on both streams follows.
// ----------------------------------------------------------------------------
module region_color_homogeneity_test;

    localparam int CLK_HALF       = 5;
    localparam int PIXEL_CAP      = 65536;
    localparam int DEV_FULL_SCALE = 25500;
    localparam int SCORE_CEILING  = 65536;
    localparam int LUMA_WEIGHT    = 70;
    localparam int CHROMA_WEIGHT  = 15;
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PIXELS  = 450;
    localparam logic [rch_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct {
        logic [16:0] score;
        logic [16:0] pixels;
    } region_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rch_pkg::S_DATA_W-1:0]   s_tdata;   // red, green, blue
    logic                           s_tuser;   // pixel_present
    logic                           s_tlast;   // end_of_region
    logic                           m_tvalid;
    logic                           m_tready;
    logic [rch_pkg::M_DATA_W-1:0]   m_tdata;   // score, pixels_seen
    logic                           cfg_we;
    logic [rch_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rch_pkg::CFG_DATA_W-1:0] cfg_data;

    // Model state: reference color and the running region accumulators.
    bit [7:0]       ref_red;
    bit [7:0]       ref_green;
    bit [7:0]       ref_blue;
    bit [31:0]      acc_deviation;
    bit [16:0]      acc_pixels;
    region_result_t pending_scores[$];

    int error_count;
    int idle_cycles;
    int pixels_sent;
    bit sender_gaps_on;
    bit receiver_stalls_on;
    bit hold_request;

    region_color_homogeneity dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Mostly short idle stretches with an occasional long one.
    function automatic int idle_length();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return int'($urandom_range(1, 3));
        else
            return int'($urandom_range(8, 30));
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Integer BT.601 conversion; the arithmetic shift gives the floor.
    function automatic void bt601_from_rgb(input bit [7:0] r, input bit [7:0] g,
                                           input bit [7:0] b, output int y,
                                           output int cb, output int cr);
        int ri;
        int gi;
        int bi;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        y  = ((66 * ri + 129 * gi + 25 * bi + 128) >>> 8) + 16;
        cb = ((-38 * ri - 74 * gi + 112 * bi + 128) >>> 8) + 128;
        cr = ((112 * ri - 94 * gi - 18 * bi + 128) >>> 8) + 128;
    endfunction

    // A channel value close to a base color, clamped to the 8-bit range.
    function automatic bit [7:0] near_color(input bit [7:0] base);
        int v;
        v = int'(base) + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // Accumulates one accepted beat and queues the score when the region ends.
    task automatic predict_homogeneity(input bit [7:0] r, input bit [7:0] g,
                                       input bit [7:0] b, input bit present,
                                       input bit last);
        int py;
        int pcb;
        int pcr;
        int qy;
        int qcb;
        int qcr;
        longint unsigned grown;
        longint unsigned num;
        longint unsigned den;
        longint unsigned quotient;
        region_result_t res;
        if (present && acc_pixels < PIXEL_CAP)
        begin
            bt601_from_rgb(r, g, b, py, pcb, pcr);
            bt601_from_rgb(ref_red, ref_green, ref_blue, qy, qcb, qcr);
            grown = 64'(acc_deviation);
            grown += 64'(LUMA_WEIGHT * magnitude(py - qy));
            grown += 64'(CHROMA_WEIGHT * magnitude(pcb - qcb));
            grown += 64'(CHROMA_WEIGHT * magnitude(pcr - qcr));
            acc_deviation = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
            acc_pixels++;
        end
        if (last)
        begin
            quotient = 0;
            if (acc_pixels != 0)
            begin
                num = 64'(acc_deviation);
                num = num << 16;
                den = 64'(acc_pixels);
                den = den * DEV_FULL_SCALE;
                quotient = num / den;
                if (quotient > SCORE_CEILING)
                    quotient = SCORE_CEILING;
            end
            res.score  = quotient[16:0];
            res.pixels = acc_pixels;
            pending_scores.push_back(res);
            acc_deviation = '0;
            acc_pixels = '0;
        end
    endtask

    // Offers one beat, waits for the handshake and updates the model.
    // Entered and left on a falling edge; tvalid stays high afterwards.
    task automatic send_beat(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b,
                             input bit present, input bit last);
        int gap;
        gap = sender_gaps_on ? idle_length() : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {b, g, r};
        s_tuser  = present;
        s_tlast  = last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_homogeneity(r, g, b, present, last);
        if (present)
            pixels_sent++;
        @(negedge clk);
    endtask

    // Waits until every expected score has come out, then lets the block drain.
    task automatic settle_block();
        s_tvalid = 1'b0;
        while (pending_scores.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [rch_pkg::CFG_IDX_W-1:0] index,
                                  input logic [rch_pkg::CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (index)
            rch_pkg::REG_REF_RED:   ref_red   = value;
            rch_pkg::REG_REF_GREEN: ref_green = value;
            rch_pkg::REG_REF_BLUE:  ref_blue  = value;
            default:                ;
        endcase
    endtask

    task automatic set_reference(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b);
        settle_block();
        write_register(rch_pkg::REG_REF_RED, r);
        write_register(rch_pkg::REG_REF_GREEN, g);
        write_register(rch_pkg::REG_REF_BLUE, b);
    endtask

    // One region of random length; pixels cluster around a base color.
    task automatic send_random_region();
        int len;
        int roll;
        bit [7:0] br;
        bit [7:0] bg;
        bit [7:0] bb;
        bit [7:0] r;
        bit [7:0] g;
        bit [7:0] b;
        roll = int'($urandom_range(0, 99));
        if (roll < 70)
            len = int'($urandom_range(1, 8));
        else if (roll < 95)
            len = int'($urandom_range(9, 32));
        else
            len = 0;
        br = 8'($urandom_range(0, 255));
        bg = 8'($urandom_range(0, 255));
        bb = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                r = 8'($urandom_range(0, 255));
                g = 8'($urandom_range(0, 255));
                b = 8'($urandom_range(0, 255));
            end
            else
            begin
                r = near_color(br);
                g = near_color(bg);
                b = near_color(bb);
            end
            // Stray pixelless beats inside the region must change nothing.
            if ($urandom_range(0, 9) == 0)
                send_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(0, 4) != 0)
                send_beat(r, g, b, 1'b1, 1'b1);
            else
                send_beat(r, g, b, 1'b1, 1'b0);
        end
        if (len == 0 || !s_tlast)
            send_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // A region with only a last beat and no pixel reports zero.
    task automatic test_empty_region();
        send_beat(8'hA5, 8'h5A, 8'hFF, 1'b0, 1'b1);
    endtask

    // Color extremes against the reset reference of black.
    task automatic test_extreme_pixels();
        send_beat(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
        send_beat(8'hFF, 8'h00, 8'h00, 1'b1, 1'b0);
        send_beat(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
        send_beat(8'h00, 8'h00, 8'hFF, 1'b1, 1'b0);
        send_beat(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_beat(8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0);
        send_beat(8'h00, 8'hFF, 8'hFF, 1'b1, 1'b1);
    endtask

    // The region ends on a beat that carries no pixel.
    task automatic test_region_closed_without_pixel();
        send_beat(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0);
        send_beat(8'h80, 8'h80, 8'h80, 1'b1, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_single_pixel_region();
        send_beat(8'h7F, 8'h01, 8'hFE, 1'b1, 1'b1);
    endtask

    // Every reference register at its extremes and at the primaries.
    task automatic test_reference_extremes();
        bit [7:0] refs[5][3] = '{'{8'hFF, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'h00},
                                 '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF},
                                 '{8'h00, 8'h00, 8'h00}};
        for (int k = 0; k < 5; k++)
        begin
            set_reference(refs[k][0], refs[k][1], refs[k][2]);
            send_beat(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
            send_beat(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
        end
    endtask

    // A write to the unused index must leave the reference color alone.
    task automatic test_spare_register_index();
        set_reference(8'd10, 8'd200, 8'd90);
        write_register(CFG_IDX_SPARE, 8'hFF);
        send_beat(8'd10, 8'd200, 8'd90, 1'b1, 1'b0);
        send_beat(8'd250, 8'd3, 8'd60, 1'b1, 1'b1);
    endtask

    // The receiver holds off for a long stretch while regions keep coming.
    task automatic test_output_backpressure();
        settle_block();
        sender_gaps_on = 1'b0;
        hold_request = 1'b1;
        for (int k = 0; k < 6; k++)
            for (int i = 0; i < 5; i++)
                send_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'b1, (i == 4));
        while (hold_request)
            @(negedge clk);
        sender_gaps_on = 1'b1;
    endtask

    // Random regions; the reference color changes every hundred pixels or so.
    task automatic test_random_regions();
        int since_change;
        bit [7:0] cr;
        bit [7:0] cg;
        bit [7:0] cb;
        since_change = 0;
        pixels_sent = 0;
        while (pixels_sent < RANDOM_PIXELS)
        begin
            if (since_change > 100)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    cr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    cg = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    cb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                else
                begin
                    cr = 8'($urandom_range(0, 255));
                    cg = 8'($urandom_range(0, 255));
                    cb = 8'($urandom_range(0, 255));
                end
                set_reference(cr, cg, cb);
                since_change = 0;
            end
            sender_gaps_on     = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
            since_change -= pixels_sent;
            send_random_region();
            since_change += pixels_sent;
        end
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    // Receiver: random stalls, or a long counted hold-off on request.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                m_tready = 1'b1;
            end
            else if (receiver_stalls_on)
            begin
                stall = idle_length();
                if (stall == 0)
                    m_tready = 1'b1;
                else
                begin
                    m_tready = 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
            else
                m_tready = 1'b1;
        end
    end

    // Scoreboard: each output beat against the oldest expected score.
    always @(posedge clk)
    begin
        region_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_scores.size() == 0)
            begin
                $display("%0t: unexpected result beat, score %0d, pixels %0d",
                         $time, m_tdata[16:0], m_tdata[33:17]);
                error_count++;
            end
            else
            begin
                want = pending_scores.pop_front();
                if (m_tdata[16:0] !== want.score)
                begin
                    $display("%0t: score mismatch: expected %0d, got %0d",
                             $time, want.score, m_tdata[16:0]);
                    error_count++;
                end
                if (m_tdata[33:17] !== want.pixels)
                begin
                    $display("%0t: pixels_seen mismatch: expected %0d, got %0d",
                             $time, want.pixels, m_tdata[33:17]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n              = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = 1'b0;
        s_tlast            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        error_count        = 0;
        idle_cycles        = 0;
        pixels_sent        = 0;
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        hold_request       = 1'b0;
        ref_red            = '0;
        ref_green          = '0;
        ref_blue           = '0;
        acc_deviation      = '0;
        acc_pixels         = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_region();
        test_extreme_pixels();
        test_region_closed_without_pixel();
        test_single_pixel_region();
        test_reference_extremes();
        test_spare_register_index();
        test_output_backpressure();
        test_random_regions();

        // Drain and watch for stray result beats.
        settle_block();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
